// File: rtl/sd_spi_init_and_stream_reader_macros.svh
// Assertion macros for the SD card SPI init and stream reader.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef SD_SPI_INIT_AND_STREAM_READER_MACROS_SVH
`define SD_SPI_INIT_AND_STREAM_READER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SDSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SDSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sdsr_pkg.sv
// Package for the SD card SPI init and stream reader: item types, command
// constants, phase encodings and register indexes. No dependencies.
`default_nettype none

package sdsr_pkg;

  localparam int BLOCK_BYTES_DEF = 512;

  localparam int unsigned CFG_AW = 4;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_START_ADDR = 2'd0;
  localparam logic [1:0] REG_POLL_LIMIT = 2'd1;
  localparam logic [1:0] REG_WAKE_BYTES = 2'd2;

  localparam logic [31:0] START_ADDR_RST = 32'd0;
  localparam logic [7:0]  POLL_LIMIT_RST = 8'd10;
  localparam logic [7:0]  WAKE_BYTES_RST = 8'd20;

  localparam logic [7:0] IDLE_BYTE  = 8'hFF;
  localparam logic [7:0] DATA_TOKEN = 8'hFE;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] IFCOND_DISCARDS = 8'd5;

  localparam logic [7:0]  CMD0_CODE   = 8'h40;
  localparam logic [7:0]  CMD0_CRC    = 8'h95;
  localparam logic [7:0]  CMD8_CODE   = 8'h48;
  localparam logic [31:0] CMD8_ARG    = 32'h0000_01AA;
  localparam logic [7:0]  CMD8_CRC    = 8'h87;
  localparam logic [7:0]  CMD55_CODE  = 8'h77;
  localparam logic [7:0]  ACMD41_CODE = 8'h69;
  localparam logic [31:0] ACMD41_ARG  = 32'h4000_0000;
  localparam logic [7:0]  CMD18_CODE  = 8'h52;
  localparam logic [7:0]  DUMMY_CRC   = 8'hFF;

  // command frame positions
  localparam logic [2:0] FR_CODE = 3'd0;
  localparam logic [2:0] FR_ARG3 = 3'd1;
  localparam logic [2:0] FR_ARG2 = 3'd2;
  localparam logic [2:0] FR_ARG1 = 3'd3;
  localparam logic [2:0] FR_ARG0 = 3'd4;
  localparam logic [2:0] FR_CRC  = 3'd5;
  localparam logic [3:0] FR_POLL_START = 4'd6;
  localparam logic [3:0] FR_POLL       = 4'd7;
  localparam logic [3:0] FR_DISCARD    = 4'd8;

  localparam logic [3:0] PHC_IDLE    = 4'd0;
  localparam logic [3:0] PHC_WAKE    = 4'd1;
  localparam logic [3:0] PHC_RESET   = 4'd2;
  localparam logic [3:0] PHC_IFCOND  = 4'd3;
  localparam logic [3:0] PHC_INIT    = 4'd4;
  localparam logic [3:0] PHC_READCMD = 4'd5;
  localparam logic [3:0] PHC_TOKEN   = 4'd6;
  localparam logic [3:0] PHC_DATA    = 4'd7;
  localparam logic [3:0] PHC_CRC     = 4'd8;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_WAKE    = 9'b000000010,
    PH_RESET   = 9'b000000100,
    PH_IFCOND  = 9'b000001000,
    PH_INIT    = 9'b000010000,
    PH_READCMD = 9'b000100000,
    PH_TOKEN   = 9'b001000000,
    PH_DATA    = 9'b010000000,
    PH_CRC     = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       card_select_n;
    logic [7:0] sample;
    logic       sample_valid;
    logic       init_failed;
    logic [3:0] phase;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/sd_spi_init_and_stream_reader.sv
// SD card SPI init and stream reader, top level.
// Depends on sdsr_pkg and sd_spi_init_and_stream_reader_macros.svh.
//
// Usage: the SPI shifter reports each finished byte exchange as an input item
// (opcode 1, rx_byte). Opcode 0 restarts the power-up sequence from any state.
// Every input item produces exactly one result item: the byte to shift out next,
// the chip-select level for that exchange, an optional audio sample and status.
// Channels use valid/stall; an item moves on an edge with valid high, stall low.
// An accepted item lands in the input register, and its result is written to the
// output register once that register is free (out_valid then rises). Throughput
// is one item per cycle while the receiver does not stall; the decision for an item
// is a single pass over the state registers between the input and output registers.
// When the receiver stalls, the output register holds its item and the input
// register takes one more; after that in_stall rises until out_stall drops.
// Reset (rst_n low, synchronous) empties both registers, sets the sequencer to
// idle and loads the register defaults: start address 0, poll limit 10, wake
// bytes 20. Registers are written over the APB port at 0, 4 and 8, by the user
// only while the block is idle; the block does not enforce it. pready is always high.
`default_nettype none

module sd_spi_init_and_stream_reader #(
  parameter int BLOCK_BYTES = sdsr_pkg::BLOCK_BYTES_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  sdsr_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  wire                         out_stall,
  output sdsr_pkg::out_item_t         out_data,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [sdsr_pkg::CFG_AW-1:0] paddr,
  input  wire  [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int CNT_W = ($clog2(BLOCK_BYTES) > 8) ? $clog2(BLOCK_BYTES) : 8;
  localparam logic [CNT_W:0] BLOCK_END = (CNT_W + 1)'(BLOCK_BYTES);
  localparam logic [CNT_W:0] CRC_END   = (CNT_W + 1)'(2);

  // configuration registers
  logic [31:0] start_addr_r;
  logic [7:0]  poll_limit_r;
  logic [7:0]  wake_bytes_r;
  logic        cfg_wr;

  // sequencer state
  sdsr_pkg::phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0]       poll_left_r, poll_left_nxt;
  logic             cmd_step_r, cmd_step_nxt;
  logic             halted_r, halted_nxt;

  // input and output registers
  logic               s1_valid_r;
  sdsr_pkg::in_item_t s1_data_r;
  logic               out_valid_r;
  sdsr_pkg::out_item_t out_data_r, out_data_nxt;
  logic               out_ready;
  logic               s1_fire;

  function automatic logic [7:0] frame_byte(sdsr_pkg::phase_t ph, logic step,
                                            logic [2:0] idx, logic [31:0] start);
    logic [7:0]  code;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  res;
    case (ph)
      sdsr_pkg::PH_RESET: begin
        code = sdsr_pkg::CMD0_CODE;  arg = 32'd0;              crc = sdsr_pkg::CMD0_CRC;
      end
      sdsr_pkg::PH_IFCOND: begin
        code = sdsr_pkg::CMD8_CODE;  arg = sdsr_pkg::CMD8_ARG;  crc = sdsr_pkg::CMD8_CRC;
      end
      sdsr_pkg::PH_INIT: begin
        if (!step) begin
          code = sdsr_pkg::CMD55_CODE;  arg = 32'd0;                crc = sdsr_pkg::DUMMY_CRC;
        end else begin
          code = sdsr_pkg::ACMD41_CODE; arg = sdsr_pkg::ACMD41_ARG; crc = sdsr_pkg::DUMMY_CRC;
        end
      end
      default: begin
        code = sdsr_pkg::CMD18_CODE; arg = start;              crc = sdsr_pkg::DUMMY_CRC;
      end
    endcase
    case (idx)
      sdsr_pkg::FR_CODE: res = code;
      sdsr_pkg::FR_ARG3: res = arg[31:24];
      sdsr_pkg::FR_ARG2: res = arg[23:16];
      sdsr_pkg::FR_ARG1: res = arg[15:8];
      sdsr_pkg::FR_ARG0: res = arg[7:0];
      default:           res = crc;
    endcase
    return res;
  endfunction

  function automatic logic [3:0] phase_code(sdsr_pkg::phase_t ph);
    logic [3:0] c;
    case (ph)
      sdsr_pkg::PH_IDLE:    c = sdsr_pkg::PHC_IDLE;
      sdsr_pkg::PH_WAKE:    c = sdsr_pkg::PHC_WAKE;
      sdsr_pkg::PH_RESET:   c = sdsr_pkg::PHC_RESET;
      sdsr_pkg::PH_IFCOND:  c = sdsr_pkg::PHC_IFCOND;
      sdsr_pkg::PH_INIT:    c = sdsr_pkg::PHC_INIT;
      sdsr_pkg::PH_READCMD: c = sdsr_pkg::PHC_READCMD;
      sdsr_pkg::PH_TOKEN:   c = sdsr_pkg::PHC_TOKEN;
      sdsr_pkg::PH_DATA:    c = sdsr_pkg::PHC_DATA;
      sdsr_pkg::PH_CRC:     c = sdsr_pkg::PHC_CRC;
      default:              c = sdsr_pkg::PHC_IDLE;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= sdsr_pkg::START_ADDR_RST;
      poll_limit_r <= sdsr_pkg::POLL_LIMIT_RST;
      wake_bytes_r <= sdsr_pkg::WAKE_BYTES_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sdsr_pkg::REG_START_ADDR: start_addr_r <= pwdata;
        sdsr_pkg::REG_POLL_LIMIT: poll_limit_r <= pwdata[7:0];
        sdsr_pkg::REG_WAKE_BYTES: wake_bytes_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sdsr_pkg::REG_START_ADDR: prdata = start_addr_r;
      sdsr_pkg::REG_POLL_LIMIT: prdata = {24'd0, poll_limit_r};
      sdsr_pkg::REG_WAKE_BYTES: prdata = {24'd0, wake_bytes_r};
      default:                  prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    logic [CNT_W:0]   cnt_inc;
    logic [7:0]       poll_dec;
    logic [7:0]       tx;
    logic [7:0]       rx;
    logic [7:0]       smp;
    logic             smp_vld;
    logic             go_cmd;
    sdsr_pkg::phase_t go_ph;
    logic             go_step;

    rx       = s1_data_r.rx_byte;
    cnt_inc  = {1'b0, byte_cnt_r} + (CNT_W + 1)'(1);
    poll_dec = (poll_left_r != 8'd0) ? poll_left_r - 8'd1 : 8'd0;
    tx       = sdsr_pkg::IDLE_BYTE;
    smp      = 8'd0;
    smp_vld  = 1'b0;
    go_cmd   = 1'b0;
    go_ph    = sdsr_pkg::PH_INIT;
    go_step  = 1'b0;

    phase_nxt     = phase_r;
    byte_cnt_nxt  = byte_cnt_r;
    poll_left_nxt = poll_left_r;
    cmd_step_nxt  = cmd_step_r;
    halted_nxt    = halted_r;

    if (s1_data_r.opcode == sdsr_pkg::OP_START) begin
      phase_nxt     = sdsr_pkg::PH_WAKE;
      byte_cnt_nxt  = '0;
      poll_left_nxt = 8'd0;
      cmd_step_nxt  = 1'b0;
      halted_nxt    = 1'b0;
    end else if (!halted_r) begin
      case (phase_r)
        sdsr_pkg::PH_WAKE: begin
          byte_cnt_nxt = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= {{(CNT_W - 7){1'b0}}, wake_bytes_r}) begin
            go_cmd = 1'b1;
            go_ph  = sdsr_pkg::PH_RESET;
          end
        end
        sdsr_pkg::PH_RESET, sdsr_pkg::PH_IFCOND, sdsr_pkg::PH_INIT,
        sdsr_pkg::PH_READCMD: begin
          if (byte_cnt_r < CNT_W'(sdsr_pkg::FR_POLL_START)) begin
            tx = frame_byte(phase_r, cmd_step_r, byte_cnt_r[2:0], start_addr_r);
            byte_cnt_nxt = cnt_inc[CNT_W-1:0];
          end else if (byte_cnt_r == CNT_W'(sdsr_pkg::FR_POLL_START)) begin
            byte_cnt_nxt  = CNT_W'(sdsr_pkg::FR_POLL);
            poll_left_nxt = (poll_limit_r == 8'd0) ? 8'd1 : poll_limit_r;
          end else if (byte_cnt_r == CNT_W'(sdsr_pkg::FR_POLL)) begin
            poll_left_nxt = poll_dec;
            if (rx != sdsr_pkg::IDLE_BYTE || poll_dec == 8'd0) begin
              // response taken (or poll timed out with 0xFF)
              case (phase_r)
                sdsr_pkg::PH_RESET: begin
                  if (rx != sdsr_pkg::R1_IDLE) begin
                    halted_nxt = 1'b1;
                  end else begin
                    go_cmd = 1'b1;
                    go_ph  = sdsr_pkg::PH_IFCOND;
                  end
                end
                sdsr_pkg::PH_IFCOND: begin
                  byte_cnt_nxt  = CNT_W'(sdsr_pkg::FR_DISCARD);
                  poll_left_nxt = sdsr_pkg::IFCOND_DISCARDS;
                end
                sdsr_pkg::PH_INIT: begin
                  go_cmd = 1'b1;
                  if (!cmd_step_r) begin
                    go_ph   = sdsr_pkg::PH_INIT;
                    go_step = 1'b1;
                  end else if (rx == sdsr_pkg::R1_READY) begin
                    go_ph = sdsr_pkg::PH_READCMD;
                  end else begin
                    go_ph = sdsr_pkg::PH_INIT;
                  end
                end
                default: begin
                  if (rx == sdsr_pkg::R1_READY) begin
                    phase_nxt    = sdsr_pkg::PH_TOKEN;
                    byte_cnt_nxt = '0;
                  end else begin
                    go_cmd = 1'b1;
                    go_ph  = sdsr_pkg::PH_READCMD;
                  end
                end
              endcase
            end
          end else begin
            // discard run after the interface condition command
            poll_left_nxt = poll_dec;
            if (poll_dec == 8'd0) begin
              go_cmd = 1'b1;
              go_ph  = sdsr_pkg::PH_INIT;
            end
          end
        end
        sdsr_pkg::PH_TOKEN: begin
          if (rx == sdsr_pkg::DATA_TOKEN) begin
            phase_nxt    = sdsr_pkg::PH_DATA;
            byte_cnt_nxt = '0;
          end
        end
        sdsr_pkg::PH_DATA: begin
          if (byte_cnt_r[0]) begin
            smp     = rx;
            smp_vld = 1'b1;
          end
          byte_cnt_nxt = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= BLOCK_END) begin
            phase_nxt    = sdsr_pkg::PH_CRC;
            byte_cnt_nxt = '0;
          end
        end
        sdsr_pkg::PH_CRC: begin
          byte_cnt_nxt = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= CRC_END) begin
            phase_nxt    = sdsr_pkg::PH_TOKEN;
            byte_cnt_nxt = '0;
          end
        end
        default: ;
      endcase
    end

    if (go_cmd) begin
      phase_nxt     = go_ph;
      cmd_step_nxt  = go_step;
      byte_cnt_nxt  = CNT_W'(1);
      poll_left_nxt = 8'd0;
      tx = frame_byte(go_ph, go_step, sdsr_pkg::FR_CODE, start_addr_r);
    end

    out_data_nxt.tx_byte       = halted_nxt ? sdsr_pkg::IDLE_BYTE : tx;
    out_data_nxt.card_select_n = halted_nxt || phase_nxt == sdsr_pkg::PH_IDLE ||
                                 phase_nxt == sdsr_pkg::PH_WAKE;
    out_data_nxt.sample        = smp;
    out_data_nxt.sample_valid  = smp_vld;
    out_data_nxt.init_failed   = halted_nxt;
    out_data_nxt.phase         = phase_code(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sdsr_pkg::PH_IDLE;
      byte_cnt_r  <= '0;
      poll_left_r <= 8'd0;
      cmd_step_r  <= 1'b0;
      halted_r    <= 1'b0;
    end else if (s1_fire) begin
      phase_r     <= phase_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      poll_left_r <= poll_left_nxt;
      cmd_step_r  <= cmd_step_nxt;
      halted_r    <= halted_nxt;
    end
  end

  // ---------------------------------------------------------------- assertions
`include "sd_spi_init_and_stream_reader_macros.svh"

  `SDSR_ASSERT_NOW(a_halt_in_reset, halted_r, phase_r == sdsr_pkg::PH_RESET,
                   "halted outside reset phase")
  `SDSR_ASSERT_NOW(a_sample_in_data, out_valid_r && out_data_r.sample_valid,
                   out_data_r.phase == sdsr_pkg::PHC_DATA ||
                   out_data_r.phase == sdsr_pkg::PHC_CRC,
                   "sample outside data block")
  `SDSR_ASSERT_NOW(a_fail_quiet, out_valid_r && out_data_r.init_failed,
                   out_data_r.card_select_n && out_data_r.tx_byte == sdsr_pkg::IDLE_BYTE,
                   "halted block drives the card")
  `SDSR_ASSERT_NEXT(a_s1_hold, s1_valid_r && !out_ready, s1_valid_r,
                    "item dropped from input register")

endmodule

`default_nettype wire

// File: test/sd_spi_init_and_stream_reader_tb.sv
// Testbench for sd_spi_init_and_stream_reader: drives received SPI bytes from a card-like
// generator, predicts every reply, and checks it field by field. Depends on sdsr_pkg.
module sd_spi_init_and_stream_reader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdsr_pkg::*;

  localparam int BLOCK_LEN = BLOCK_BYTES_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  sd_spi_init_and_stream_reader #(.BLOCK_BYTES(BLOCK_LEN)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register shadows
  logic [31:0] addr_setting = START_ADDR_RST;
  logic [7:0]  poll_setting = POLL_LIMIT_RST;
  logic [7:0]  wake_setting = WAKE_BYTES_RST;

  // sequencer state as the card sees it
  logic [3:0] seq_phase = PHC_IDLE;
  logic [9:0] seq_count = '0;
  logic [7:0] seq_polls = '0;
  logic       seq_acmd = 1'b0;
  logic       seq_halted = 1'b0;
  logic [7:0] tx_next = IDLE_BYTE;

  out_item_t pending_replies[$];
  int mismatches = 0;
  int cycle_count = 0;
  int hold_off_len = 0;
  bit idling_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sd_spi_init_and_stream_reader_tb failed");
    $finish;
  end

  function automatic logic [7:0] cmd_frame_byte(input logic [9:0] pos);
    logic [7:0] code;
    logic [7:0] crc;
    logic [31:0] arg;
    case (seq_phase)
      PHC_RESET: begin
        code = CMD0_CODE; arg = '0; crc = CMD0_CRC;
      end
      PHC_IFCOND: begin
        code = CMD8_CODE; arg = CMD8_ARG; crc = CMD8_CRC;
      end
      PHC_INIT: begin
        if (!seq_acmd) begin
          code = CMD55_CODE; arg = '0;
        end else begin
          code = ACMD41_CODE; arg = ACMD41_ARG;
        end
        crc = DUMMY_CRC;
      end
      default: begin
        code = CMD18_CODE; arg = addr_setting; crc = DUMMY_CRC;
      end
    endcase
    if (pos == 0) return code;
    // argument goes out most significant byte first
    if (pos <= 4) return 8'(arg >> (8 * (4 - int'(pos))));
    return crc;
  endfunction

  function automatic void begin_command(input logic [3:0] ph, input logic step);
    seq_phase = ph;
    seq_acmd = step;
    seq_count = 10'd1;
    seq_polls = '0;
    tx_next = cmd_frame_byte(10'd0);
  endfunction

  function automatic void judge_response(input logic [7:0] resp);
    case (seq_phase)
      PHC_RESET: begin
        if (resp != R1_IDLE) begin
          seq_halted = 1'b1;
          tx_next = IDLE_BYTE;
        end else begin
          begin_command(PHC_IFCOND, 1'b0);
        end
      end
      PHC_IFCOND: begin
        seq_count = 10'(FR_DISCARD);
        seq_polls = IFCOND_DISCARDS;
        tx_next = IDLE_BYTE;
      end
      PHC_INIT: begin
        if (!seq_acmd) begin_command(PHC_INIT, 1'b1);
        else if (resp == R1_READY) begin_command(PHC_READCMD, 1'b0);
        else begin_command(PHC_INIT, 1'b0);
      end
      default: begin
        if (resp == R1_READY) begin
          seq_phase = PHC_TOKEN;
          seq_count = '0;
          tx_next = IDLE_BYTE;
        end else begin
          begin_command(PHC_READCMD, 1'b0);
        end
      end
    endcase
  endfunction

  // advance the sequencer by one received byte and return the reply
  function automatic out_item_t advance_sequencer(input in_item_t it);
    out_item_t r;
    r = '0;
    tx_next = IDLE_BYTE;
    if (it.opcode == OP_START) begin
      seq_phase = PHC_WAKE;
      seq_count = '0;
      seq_polls = '0;
      seq_acmd = 1'b0;
      seq_halted = 1'b0;
    end else if (!seq_halted) begin
      case (seq_phase)
        PHC_WAKE: begin
          seq_count = seq_count + 10'd1;
          if (seq_count >= 10'(wake_setting)) begin_command(PHC_RESET, 1'b0);
        end
        PHC_RESET, PHC_IFCOND, PHC_INIT, PHC_READCMD: begin
          if (seq_count < 10'(FR_POLL_START)) begin
            tx_next = cmd_frame_byte(seq_count);
            seq_count = seq_count + 10'd1;
          end else if (seq_count == 10'(FR_POLL_START)) begin
            seq_count = 10'(FR_POLL);
            seq_polls = (poll_setting == 0) ? 8'd1 : poll_setting;
          end else if (seq_count == 10'(FR_POLL)) begin
            if (seq_polls > 0) seq_polls = seq_polls - 8'd1;
            if (it.rx_byte != IDLE_BYTE || seq_polls == 0) judge_response(it.rx_byte);
          end else begin
            // discard run after the interface condition response
            if (seq_polls > 0) seq_polls = seq_polls - 8'd1;
            if (seq_polls == 0) begin_command(PHC_INIT, 1'b0);
          end
        end
        PHC_TOKEN: begin
          if (it.rx_byte == DATA_TOKEN) begin
            seq_phase = PHC_DATA;
            seq_count = '0;
          end
        end
        PHC_DATA: begin
          if (seq_count[0]) begin
            r.sample = it.rx_byte;
            r.sample_valid = 1'b1;
          end
          seq_count = seq_count + 10'd1;
          if (int'(seq_count) >= BLOCK_LEN) begin
            seq_phase = PHC_CRC;
            seq_count = '0;
          end
        end
        PHC_CRC: begin
          seq_count = seq_count + 10'd1;
          if (seq_count >= 10'd2) begin
            seq_phase = PHC_TOKEN;
            seq_count = '0;
          end
        end
        default: ;
      endcase
    end
    if (seq_halted) tx_next = IDLE_BYTE;
    r.tx_byte = tx_next;
    r.card_select_n = seq_halted || seq_phase == PHC_IDLE || seq_phase == PHC_WAKE;
    r.init_failed = seq_halted;
    r.phase = seq_phase;
    return r;
  endfunction

  // pick what a card would answer next; noisy items ignore the protocol
  function automatic in_item_t card_byte(input bit noisy, input bit lazy);
    in_item_t it;
    int roll;
    roll = $urandom_range(0, 99);
    it.opcode = OP_REPORT;
    it.rx_byte = 8'($urandom_range(0, 255));
    if (noisy) begin
      if (roll < 5) it.opcode = OP_START;
      return it;
    end
    if (seq_phase == PHC_IDLE || (seq_halted && roll < 30)) begin
      it.opcode = OP_START;
      return it;
    end
    if (seq_halted) return it;
    if (seq_phase >= PHC_RESET && seq_phase <= PHC_READCMD && seq_count == 10'(FR_POLL)) begin
      if (lazy ? roll < 85 : roll < 15) begin
        it.rx_byte = IDLE_BYTE;
      end else begin
        roll = $urandom_range(0, 99);
        case (seq_phase)
          PHC_RESET: if (roll < 85) it.rx_byte = R1_IDLE;
          PHC_INIT: begin
            if (seq_acmd && roll < 50) it.rx_byte = R1_READY;
            else if (roll < 80) it.rx_byte = R1_IDLE;
          end
          PHC_READCMD: if (roll < 70) it.rx_byte = R1_READY;
          default: ;
        endcase
      end
    end else if (seq_phase == PHC_TOKEN) begin
      if (roll < 30) it.rx_byte = DATA_TOKEN;
      else if (roll < 70) it.rx_byte = IDLE_BYTE;
    end
    return it;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t reply mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_START_ADDR: addr_setting = value;
      REG_POLL_LIMIT: poll_setting = value[7:0];
      REG_WAKE_BYTES: wake_setting = value[7:0];
      default: ;
    endcase
  endtask

  task automatic send_card_byte(input in_item_t it);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(advance_sequencer(it));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_stream(input int count, input bit lazy, input int noise_pct,
                            input int hold_at);
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_off_len = 300;
      send_card_byte(card_byte($urandom_range(0, 99) < noise_pct, lazy));
    end
  endtask

  // idle reports, bad reset response, halted reports, restart, poll timeout
  task automatic test_halt_and_idle();
    logic [7:0] junk [6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
    write_reg(REG_POLL_LIMIT, 32'd0);
    write_reg(REG_WAKE_BYTES, 32'd0);
    send_card_byte('{OP_REPORT, 8'hFF});
    send_card_byte('{OP_REPORT, 8'h00});
    send_card_byte('{OP_START, 8'hFF});
    send_card_byte('{OP_REPORT, 8'h55});
    foreach (junk[i]) send_card_byte('{OP_REPORT, junk[i]});
    send_card_byte('{OP_REPORT, 8'h05});
    send_card_byte('{OP_REPORT, 8'h01});
    send_card_byte('{OP_REPORT, 8'h00});
    send_card_byte('{OP_START, 8'h00});
    send_card_byte('{OP_REPORT, 8'hAA});
    foreach (junk[i]) send_card_byte('{OP_REPORT, ~junk[i]});
    // a silent card times out after a single poll
    send_card_byte('{OP_REPORT, 8'hFF});
    send_card_byte('{OP_REPORT, 8'h01});
    wait_drained();
  endtask

  task automatic test_stream_with_backpressure();
    write_reg(REG_START_ADDR, 32'hFFFF_FFFF);
    write_reg(REG_POLL_LIMIT, 32'd1);
    write_reg(REG_WAKE_BYTES, 32'd10);
    run_stream(700, 1'b0, 0, 300);
    wait_drained();
  endtask

  task automatic test_slow_card();
    write_reg(REG_START_ADDR, 32'd0);
    write_reg(REG_POLL_LIMIT, 32'd255);
    write_reg(REG_WAKE_BYTES, 32'd255);
    run_stream(350, 1'b1, 0, -1);
    wait_drained();
  endtask

  task automatic test_noise_and_restarts();
    write_reg(REG_START_ADDR, $urandom());
    write_reg(REG_POLL_LIMIT, 32'($urandom_range(1, 6)));
    write_reg(REG_WAKE_BYTES, 32'($urandom_range(10, 14)));
    run_stream(150, 1'b0, 40, -1);
    idling_on = 1'b0;
    run_stream(100, 1'b0, 10, -1);
    wait_drained();
  endtask

  initial begin : receiver
    int burst;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        burst = hold_off_len;
        hold_off_len = 0;
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : reply_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        note_mismatch("reply with nothing outstanding");
      end else begin
        want = pending_replies.pop_front();
        if (out_data.tx_byte !== want.tx_byte)
          note_mismatch($sformatf("tx_byte %02h, want %02h", out_data.tx_byte, want.tx_byte));
        if (out_data.card_select_n !== want.card_select_n)
          note_mismatch($sformatf("card_select_n %b, want %b",
                                  out_data.card_select_n, want.card_select_n));
        if (out_data.sample !== want.sample)
          note_mismatch($sformatf("sample %02h, want %02h", out_data.sample, want.sample));
        if (out_data.sample_valid !== want.sample_valid)
          note_mismatch($sformatf("sample_valid %b, want %b",
                                  out_data.sample_valid, want.sample_valid));
        if (out_data.init_failed !== want.init_failed)
          note_mismatch($sformatf("init_failed %b, want %b",
                                  out_data.init_failed, want.init_failed));
        if (out_data.phase !== want.phase)
          note_mismatch($sformatf("phase %0d, want %0d", out_data.phase, want.phase));
      end
    end
  end

  initial begin : main
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_halt_and_idle();
    test_stream_with_backpressure();
    test_slow_card();
    test_noise_and_restarts();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("sd_spi_init_and_stream_reader_tb passed");
    end else begin
      $display("sd_spi_init_and_stream_reader_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sdsr_pkg.sv
rtl/sd_spi_init_and_stream_reader.sv
test/sd_spi_init_and_stream_reader_tb.sv
